[rtl/interval_reservation_checker_unit_macros.svh]
// Assertion macros for the interval reservation checker.
`ifndef INTERVAL_RESERVATION_CHECKER_UNIT_MACROS_SVH
`define INTERVAL_RESERVATION_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define IRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define IRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/irc_pkg.sv]
// Package: shared types and codes of the interval reservation checker.
`default_nettype none
package irc_pkg;

    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_OVERLAP   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
        logic rd_pend;
        logic out_free;
        logic malformed;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/irc_dp.sv]
// Datapath: range table memory, scan compare, fill count and result register.
`default_nettype none
`include "interval_reservation_checker_unit_macros.svh"
module irc_dp #(
    parameter int MAX_REGIONS = 64,
    parameter int ADDR_BITS   = 30
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire irc_pkg::t_dp_cmd     i_cmd,
    output irc_pkg::t_dp_sts          o_sts,
    input  wire logic [ADDR_BITS-1:0] i_start_addr,
    input  wire logic [ADDR_BITS-1:0] i_end_addr,
    input  wire logic                 i_m_tready,
    output logic                      o_m_tvalid,
    output logic [1:0]                o_status
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int ENT_W = 2 * ADDR_BITS;

    logic [ENT_W-1:0]     r_mem [MAX_REGIONS];
    logic [ENT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;
    logic [ADDR_BITS-1:0] r_lo;
    logic [ADDR_BITS-1:0] r_hi;
    logic [CNT_W-1:0]     r_scan;
    logic [CNT_W-1:0]     r_count;
    logic                 r_hit;
    logic                 r_out_valid;
    logic [1:0]           r_status;

    logic [ADDR_BITS-1:0] w_rd_start;
    logic [ADDR_BITS-1:0] w_rd_end;
    logic                 w_hit;
    logic                 w_malformed;
    logic                 w_full;
    logic [1:0]           n_status;
    logic                 w_wr_en;

    assign w_rd_start  = r_rd_data[ADDR_BITS-1:0];
    assign w_rd_end    = r_rd_data[ENT_W-1:ADDR_BITS];
    assign w_hit       = r_rd_vld && !((r_hi < w_rd_start) || (r_lo > w_rd_end));
    assign w_malformed = r_lo > r_hi;
    assign w_full      = r_count == CNT_W'(MAX_REGIONS);

    always_comb begin
        if (w_malformed) begin
            n_status = irc_pkg::ST_MALFORMED;
        end else if (r_hit) begin
            n_status = irc_pkg::ST_OVERLAP;
        end else if (w_full) begin
            n_status = irc_pkg::ST_FULL;
        end else begin
            n_status = irc_pkg::ST_ACCEPTED;
        end
    end

    assign w_wr_en = i_cmd.emit && (n_status == irc_pkg::ST_ACCEPTED);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_hi, r_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rd_data <= r_mem[r_scan[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo <= i_start_addr;
            r_hi <= i_end_addr;
        end
        if (i_cmd.emit) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_scan      <= '0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
            if (i_cmd.load) begin
                r_scan <= '0;
                r_hit  <= 1'b0;
            end else begin
                if (i_cmd.step) begin
                    r_scan <= r_scan + CNT_W'(1);
                end
                if (w_hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (w_wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.more      = r_scan < r_count;
    assign o_sts.rd_pend   = r_rd_vld;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;
    assign o_sts.malformed = w_malformed;
    assign o_m_tvalid      = r_out_valid;
    assign o_status        = r_status;

    `IRC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_REGIONS), "fill count past table size")
    `IRC_ASSERT_NOW(a_write_clean, i_clk, i_rst_n, w_wr_en, !r_hit && !w_malformed && !w_full, "write of a refused range")
    `IRC_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !w_wr_en, $stable(r_count), "fill count moved without a write")

endmodule
`default_nettype wire

[rtl/irc_ctrl.sv]
// Controller: sequences accept, table scan and result issue.
`default_nettype none
`include "interval_reservation_checker_unit_macros.svh"
module irc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire irc_pkg::t_dp_sts i_sts,
    output irc_pkg::t_dp_cmd      o_cmd
);

    irc_pkg::t_state r_state;
    irc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            irc_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = irc_pkg::S_SCAN;
                end
            end
            irc_pkg::S_SCAN: begin
                if (i_sts.malformed || (!i_sts.more && !i_sts.rd_pend)) begin
                    n_state = irc_pkg::S_RESULT;
                end
            end
            irc_pkg::S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = irc_pkg::S_IDLE;
                end
            end
            default: n_state = irc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            irc_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            irc_pkg::S_SCAN: begin
                o_cmd.step = i_sts.more && !i_sts.malformed;
            end
            irc_pkg::S_RESULT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    `IRC_ASSERT_NOW(a_step_in_range, i_clk, i_rst_n, o_cmd.step, i_sts.more, "read past fill count")
    `IRC_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free, "result issued into a full output")
    `IRC_ASSERT_NOW(a_emit_drained, i_clk, i_rst_n, o_cmd.emit, !i_sts.rd_pend, "result issued with a compare pending")

endmodule
`default_nettype wire

[rtl/interval_reservation_checker_unit.sv]
// Interval reservation checker: the top level. Each item carries a closed
// range [start, end]; it is compared one table entry per cycle against every
// range reserved so far (a single read port of the range memory sets the
// pace), then either stored at the next free entry or refused. The scan
// covers every range already reserved; an item that meets an empty table,
// or a range whose start lies after its end, skips the scan. The result
// waits for the output register to be free before it is issued.
// The result sits in an output register, so the next item is taken while a
// result still waits. The table needs no clearing after reset.
`default_nettype none
module interval_reservation_checker_unit #(
    parameter int MAX_REGIONS = 64,
    parameter int ADDR_BITS   = 30
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // start_addr, end_addr
    input  wire logic [((2*ADDR_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // status
    output logic [7:0]               o_m_axis_tdata
);

    irc_pkg::t_dp_cmd w_cmd;
    irc_pkg::t_dp_sts w_sts;
    logic [1:0]       w_status;

    irc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    irc_dp #(
        .MAX_REGIONS (MAX_REGIONS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_start_addr (i_s_axis_tdata[ADDR_BITS-1:0]),
        .i_end_addr   (i_s_axis_tdata[2*ADDR_BITS-1:ADDR_BITS]),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tvalid   (o_m_axis_tvalid),
        .o_status     (w_status)
    );

    assign o_m_axis_tdata = {6'b0, w_status};

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the interval reservation checker: range requests checked against a predicted table.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REGIONS  = 64;
    localparam int ADDR_BITS    = 30;
    localparam int DATA_W       = ((2*ADDR_BITS+7)/8)*8;
    localparam int ITEM_TARGET  = 1850;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_OFF_LEN = 300;

    typedef logic [ADDR_BITS-1:0] t_addr;
    localparam t_addr ADDR_TOP = '1;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              src_valid = 1'b0;
    logic              src_ready;
    logic [DATA_W-1:0] src_data  = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    logic [7:0]        res_data;

    // predicted reservation table
    t_addr       rsv_lo [MAX_REGIONS];
    t_addr       rsv_hi [MAX_REGIONS];
    int unsigned rsv_count = 0;

    logic [1:0]  pending_status [$];
    int unsigned n_sent       = 0;
    int unsigned n_errors     = 0;
    int unsigned idle_cycles  = 0;
    int unsigned hold_off_req = 0;
    bit          src_idle_on  = 1'b0;
    bit          snk_idle_on  = 1'b0;

    interval_reservation_checker_unit #(
        .MAX_REGIONS(MAX_REGIONS),
        .ADDR_BITS  (ADDR_BITS)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(src_valid),
        .o_s_axis_tready(src_ready),
        .i_s_axis_tdata (src_data),
        .o_m_axis_tvalid(res_valid),
        .i_m_axis_tready(res_ready),
        .o_m_axis_tdata (res_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic [1:0] reserve_range(t_addr lo, t_addr hi);
        bit hit = 1'b0;
        if (lo > hi) return irc_pkg::ST_MALFORMED;
        for (int k = 0; k < rsv_count; k++) begin
            if (!(hi < rsv_lo[k] || lo > rsv_hi[k])) hit = 1'b1;
        end
        if (hit) return irc_pkg::ST_OVERLAP;
        if (rsv_count >= MAX_REGIONS) return irc_pkg::ST_FULL;
        rsv_lo[rsv_count] = lo;
        rsv_hi[rsv_count] = hi;
        rsv_count++;
        return irc_pkg::ST_ACCEPTED;
    endfunction

    function automatic int unsigned pick_gap(bit enable);
        int unsigned r;
        if (!enable) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // mostly short spans, now and then a wide one
    function automatic int unsigned rand_len();
        int unsigned sh;
        sh = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 30) : $urandom_range(0, 20);
        return $urandom & ((32'd1 << sh) - 1);
    endfunction

    function automatic t_addr clamp_top(longint unsigned v);
        return (v > ADDR_TOP) ? ADDR_TOP : t_addr'(v);
    endfunction

    function automatic void pick_range(output t_addr lo, output t_addr hi);
        int unsigned kind, k, p, s1;
        kind = $urandom_range(0, 99);
        lo   = t_addr'($urandom);
        hi   = clamp_top(64'(lo) + rand_len());
        if (kind < 8) begin
            lo = t_addr'($urandom_range(1, ADDR_TOP));
            hi = t_addr'($urandom_range(0, lo - 1));
        end else if (kind < 40 && rsv_count != 0) begin
            k  = $urandom_range(0, rsv_count - 1);
            p  = $urandom_range(rsv_lo[k], rsv_hi[k]);
            s1 = rand_len();
            lo = (p > s1) ? t_addr'(p - s1) : '0;
            hi = clamp_top(64'(p) + rand_len());
        end else if (kind < 55 && rsv_count != 0) begin
            // touch an existing range from one side
            k = $urandom_range(0, rsv_count - 1);
            if ($urandom_range(0, 1) == 1 && rsv_hi[k] != ADDR_TOP) begin
                lo = rsv_hi[k] + 1'b1;
                hi = clamp_top(64'(lo) + rand_len());
            end else if (rsv_lo[k] != '0) begin
                hi = rsv_lo[k] - 1'b1;
                s1 = rand_len();
                lo = (hi > s1) ? t_addr'(hi - s1) : '0;
            end
        end
    endfunction

    task automatic send_range(input t_addr lo, input t_addr hi);
        int unsigned gap;
        gap = pick_gap(src_idle_on);
        if (gap != 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= DATA_W'({hi, lo});
        @(posedge clk);
        while (!src_ready) @(posedge clk);
        pending_status.push_back(reserve_range(lo, hi));
        n_sent++;
    endtask

    task automatic send_random(input int unsigned count);
        t_addr lo, hi;
        repeat (count) begin
            pick_range(lo, hi);
            send_range(lo, hi);
        end
    endtask

    task automatic test_directed_edges();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        send_range(30'd1, 30'd0);
        send_range(ADDR_TOP, 30'd0);
        send_range(30'd0, 30'd0);
        send_range(30'd0, 30'd0);
        send_range(30'd1, 30'd1);
        send_range(ADDR_TOP, ADDR_TOP);
        send_range(ADDR_TOP - 1'b1, ADDR_TOP);
        send_range(30'd0, ADDR_TOP);
        send_range(30'd2, 30'h3ff);
        send_range(30'h400, 30'h400);
        send_range(30'h3ff, 30'h400);
        send_range(30'h401, 30'h401);
        send_range(30'h2000_0000, 30'h2fff_ffff);
        send_range(30'h1fff_ffff, 30'h1fff_ffff);
        send_range(30'h3000_0000, 30'h3000_0000);
        send_range(30'h2555_5555, 30'h2aaa_aaaa);
        send_range(30'h1000_0000, ADDR_TOP - 1'b1);
        send_range(30'h2aaa_aaaa, 30'h1555_5555);
        send_range(30'h1555_5555, 30'h1555_5555);
        send_range(30'h0aaa_aaaa, 30'h0aaa_aaab);
    endtask

    task automatic test_fill_table();
        t_addr       lo, hi;
        int unsigned tries = 0;
        while (rsv_count < MAX_REGIONS && tries < 800) begin
            pick_range(lo, hi);
            send_range(lo, hi);
            tries++;
        end
        // once the table is full, free ranges get refused as well
        send_random(30);
    endtask

    task automatic test_output_hold_off();
        src_idle_on  = 1'b0;
        hold_off_req = HOLD_OFF_LEN;
        send_random(16);
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_mix();
        int unsigned phase = 0;
        while (n_sent < ITEM_TARGET) begin
            src_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
            snk_idle_on = (phase % 4 == 0) || (phase % 4 == 1);
            send_random(150);
            phase++;
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        forever begin
            @(posedge clk);
            if (hold_off_req != 0) begin
                stall        = hold_off_req;
                hold_off_req = 0;
            end else begin
                stall = pick_gap(snk_idle_on);
            end
            if (stall != 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_status
        logic [7:0] want;
        if (rst_n && res_valid && res_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t ns: unexpected item, expected none, actual 0x%0h", $time, res_data);
                n_errors++;
            end else begin
                want = {6'b0, pending_status.pop_front()};
                if (res_data !== want) begin
                    $display("%0t ns: status mismatch, expected 0x%0h, actual 0x%0h",
                             $time, want, res_data);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((src_valid && src_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin : run_tests
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_fill_table();
        test_output_hold_off();
        test_random_mix();
        src_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/irc_pkg.sv
rtl/irc_dp.sv
rtl/irc_ctrl.sv
rtl/interval_reservation_checker_unit.sv
dv/tb_top.sv
